/* design/nmec_pkg.sv */
// ----------------------------------------------------------------------------
// nmec_pkg: shared types and constants for the non-manifold edge counter
// Table geometry, vertex and count widths, and channel payload records.
// ----------------------------------------------------------------------------
package nmec_pkg;

   localparam int MAX_EDGES   = 1024;
   localparam int VERTEX_BITS = 16;
   localparam int COUNT_BITS  = 8;
   localparam int SLOT_BITS   = $clog2(MAX_EDGES);
   localparam int TOTAL_BITS  = SLOT_BITS + 1;
   localparam int SKIP_BITS   = 2;
   localparam int EDGE_BITS   = 2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] FACE_LIMIT = COUNT_BITS'(2);

   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef struct packed {
      logic                   mode;
      logic [VERTEX_BITS-1:0] vertex_a;
      logic [VERTEX_BITS-1:0] vertex_b;
      logic [VERTEX_BITS-1:0] vertex_c;
      logic [SLOT_BITS-1:0]   read_slot;
   } req_type;

   typedef struct packed {
      logic [TOTAL_BITS-1:0]  stored_edges;
      logic [SKIP_BITS-1:0]   skipped_degenerate;
      logic                   overflow;
      logic                   slot_valid;
      logic [VERTEX_BITS-1:0] edge_start;
      logic [VERTEX_BITS-1:0] edge_end;
      logic [COUNT_BITS-1:0]  faces_on_edge;
      logic                   streamer_risk;
   } rsp_type;

   typedef struct packed {
      logic [VERTEX_BITS-1:0] first;
      logic [VERTEX_BITS-1:0] second;
      logic [COUNT_BITS-1:0]  count;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

endpackage

/* design/nmec_if.sv */
// ----------------------------------------------------------------------------
// nmec_req_if / nmec_rsp_if: valid-ready channels of the edge counter
// Each carries valid, ready and one payload record per transfer.
// ----------------------------------------------------------------------------
interface nmec_req_if;
   import nmec_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface nmec_rsp_if;
   import nmec_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* design/nmec_ram.sv */
// ----------------------------------------------------------------------------
// nmec_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module nmec_ram #(
   parameter int WIDTH     = 8,
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/nmec_match.sv */
// ----------------------------------------------------------------------------
// nmec_match: edge compare and count update unit
// Matches a stored edge against the probe in either orientation and
// forms the saturated face count for a hit.
// ----------------------------------------------------------------------------
module nmec_match (
   input  nmec_pkg::entry_type                  entry,
   input  logic [nmec_pkg::VERTEX_BITS-1:0]     probe_p,
   input  logic [nmec_pkg::VERTEX_BITS-1:0]     probe_q,
   output logic                                 hit,
   output nmec_pkg::entry_type                  entry_next
);
   import nmec_pkg::*;

   assign hit = ((entry.first == probe_p) && (entry.second == probe_q)) ||
                ((entry.first == probe_q) && (entry.second == probe_p));

   always_comb begin
      entry_next = entry;
      if (entry.count != COUNT_MAX) begin
         entry_next.count = entry.count + COUNT_BITS'(1);
      end
   end

endmodule

/* design/nonmanifold_edge_counter.sv */
// ----------------------------------------------------------------------------
// nonmanifold_edge_counter: edge table builder with per-edge face counts
//
// req channel: one transfer per item. Mode add takes a triangle (a,b,c) and
// processes edges (a,b), (b,c), (c,a) in turn; zero-length edges are
// skipped and counted. Each other edge is searched linearly in the edge
// table, one entry per cycle through the single RAM read port and the
// shared compare unit; a hit bumps the saturating face count, a miss
// appends the edge or flags overflow when the table is full. Mode read
// returns one table slot with its endpoints, count and streamer flag.
// rsp channel: exactly one transfer per item, held in an output register.
// Read mode passes ST_READ and ST_RESP; add mode run time grows with the
// stored edges, set by the sequential table scan.
// The next item is accepted once the result sits in the output register,
// even while the receiver stalls; a further result waits in the sequencer.
// Reset clears the edge total and the sequencer; table contents are not
// cleared, only slots below the total are ever read.
// ----------------------------------------------------------------------------
module nonmanifold_edge_counter (
   input  logic              clock,
   input  logic              reset,
   nmec_req_if.sink          req_if,
   nmec_rsp_if.source        rsp_if
);
   import nmec_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EDGE = 5'b00010,
      ST_SCAN = 5'b00100,
      ST_READ = 5'b01000,
      ST_RESP = 5'b10000
   } state_type;

   localparam logic [EDGE_BITS-1:0] EDGE_AB = 2'd0;
   localparam logic [EDGE_BITS-1:0] EDGE_BC = 2'd1;
   localparam logic [EDGE_BITS-1:0] EDGE_CA = 2'd2;

   state_type              state_ff, state_in;
   req_type                item_ff, item_in;
   logic                   slot_hit_ff, slot_hit_in;
   logic [EDGE_BITS-1:0]   edge_ff, edge_in;
   logic [SKIP_BITS-1:0]   skip_ff, skip_in;
   logic                   drop_ff, drop_in;
   logic [VERTEX_BITS-1:0] p_ff, p_in, q_ff, q_in;
   logic [TOTAL_BITS-1:0]  scan_ff, scan_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic [SLOT_BITS-1:0]   rd_addr_ff, rd_addr_in;
   logic [TOTAL_BITS-1:0]  total_ff, total_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   ram_wr_en, ram_rd_en;
   logic [SLOT_BITS-1:0]   ram_wr_addr, ram_rd_addr;
   entry_type              ram_wr_data, ram_rd_entry;
   logic [ENTRY_BITS-1:0]  ram_rd_data;

   logic                   match_hit;
   entry_type              match_next;
   logic [VERTEX_BITS-1:0] sel_p, sel_q;
   logic                   table_full;

   nmec_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MAX_EDGES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ram_rd_entry = entry_type'(ram_rd_data);

   nmec_match u_match (
      .entry      (ram_rd_entry),
      .probe_p    (p_ff),
      .probe_q    (q_ff),
      .hit        (match_hit),
      .entry_next (match_next)
   );

   assign table_full   = (total_ff == TOTAL_BITS'(MAX_EDGES));
   assign req_if.ready = (state_ff == ST_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_ff;

   always_comb begin
      unique case (edge_ff)
         EDGE_AB: begin
            sel_p = item_ff.vertex_a;
            sel_q = item_ff.vertex_b;
         end
         EDGE_BC: begin
            sel_p = item_ff.vertex_b;
            sel_q = item_ff.vertex_c;
         end
         EDGE_CA: begin
            sel_p = item_ff.vertex_c;
            sel_q = item_ff.vertex_a;
         end
         default: begin
            sel_p = item_ff.vertex_a;
            sel_q = item_ff.vertex_b;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      slot_hit_in  = slot_hit_ff;
      edge_in      = edge_ff;
      skip_in      = skip_ff;
      drop_in      = drop_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      scan_in      = scan_ff;
      rd_pend_in   = rd_pend_ff;
      rd_addr_in   = rd_addr_ff;
      total_in     = total_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = rd_addr_ff;
      ram_wr_data  = match_next;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = scan_ff[SLOT_BITS-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               item_in     = req_if.data;
               slot_hit_in = ({1'b0, req_if.data.read_slot} < total_ff);
               edge_in     = EDGE_AB;
               skip_in     = '0;
               drop_in     = 1'b0;
               state_in    = (req_if.data.mode == MODE_READ) ? ST_READ : ST_EDGE;
            end
         end
         ST_EDGE: begin
            if (sel_p == sel_q) begin
               skip_in = skip_ff + SKIP_BITS'(1);
               if (edge_ff == EDGE_CA) begin
                  state_in = ST_RESP;
               end else begin
                  edge_in = edge_ff + EDGE_BITS'(1);
               end
            end else begin
               p_in       = sel_p;
               q_in       = sel_q;
               scan_in    = '0;
               rd_pend_in = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            priority if (rd_pend_ff && match_hit) begin
               ram_wr_en  = 1'b1;
               rd_pend_in = 1'b0;
               state_in   = (edge_ff == EDGE_CA) ? ST_RESP : ST_EDGE;
               edge_in    = edge_ff + EDGE_BITS'(1);
            end else if (scan_ff < total_ff) begin
               ram_rd_en  = 1'b1;
               rd_pend_in = 1'b1;
               rd_addr_in = scan_ff[SLOT_BITS-1:0];
               scan_in    = scan_ff + TOTAL_BITS'(1);
            end else if (!rd_pend_ff) begin
               if (table_full) begin
                  drop_in = 1'b1;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = total_ff[SLOT_BITS-1:0];
                  ram_wr_data = '{first: p_ff, second: q_ff, count: COUNT_BITS'(1)};
                  total_in    = total_ff + TOTAL_BITS'(1);
               end
               state_in = (edge_ff == EDGE_CA) ? ST_RESP : ST_EDGE;
               edge_in  = edge_ff + EDGE_BITS'(1);
            end else begin
               rd_pend_in = 1'b0;
            end
         end
         ST_READ: begin
            ram_rd_en   = slot_hit_ff;
            ram_rd_addr = item_ff.read_slot;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_in              = '0;
               rsp_in.stored_edges = total_ff;
               if (item_ff.mode == MODE_ADD) begin
                  rsp_in.skipped_degenerate = skip_ff;
                  rsp_in.overflow           = drop_ff;
               end else if (slot_hit_ff) begin
                  rsp_in.slot_valid    = 1'b1;
                  rsp_in.edge_start    = ram_rd_entry.first;
                  rsp_in.edge_end      = ram_rd_entry.second;
                  rsp_in.faces_on_edge = ram_rd_entry.count;
                  rsp_in.streamer_risk = (ram_rd_entry.count > FACE_LIMIT);
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      slot_hit_ff <= slot_hit_in;
      edge_ff     <= edge_in;
      skip_ff     <= skip_in;
      drop_ff     <= drop_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      scan_ff     <= scan_in;
      rd_addr_ff  <= rd_addr_in;
      rsp_ff      <= rsp_in;
   end

`ifndef SYNTHESIS
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TOTAL_BITS'(MAX_EDGES))
      else $error("edge total above table depth");

   a_total_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> total_ff >= $past(total_ff))
      else $error("edge total decreased");

   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> state_ff == ST_SCAN)
      else $error("table write outside scan");

   a_pend_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && rd_pend_ff) |-> {1'b0, rd_addr_ff} < total_ff)
      else $error("scan read beyond stored edges");
`endif

endmodule

/* tb/tb_nonmanifold_edge_counter.sv */
// ----------------------------------------------------------------------------
// tb_nonmanifold_edge_counter: self-checking bench for the edge counter
// Drives triangles and slot reads with random idle gaps on both channels.
// A scoreboard keeps its own edge table and checks every response field by
// field. The run covers degenerate edges, reversed orientation, empty and
// out-of-range slot reads, and face count saturation.
// ----------------------------------------------------------------------------
module tb_nonmanifold_edge_counter;
   import nmec_pkg::*;

   class edge_table_scoreboard;
      logic [VERTEX_BITS-1:0] first_vtx  [MAX_EDGES];
      logic [VERTEX_BITS-1:0] second_vtx [MAX_EDGES];
      logic [COUNT_BITS-1:0]  face_cnt   [MAX_EDGES];
      int                     edge_total;
      rsp_type                expected_rsp [$];
      int                     mismatches;
      int                     triangles;
      int                     slot_reads;
      int                     overflow_hits;
      int                     peak_count;

      function bit tally_edge(input logic [VERTEX_BITS-1:0] p, q, inout bit dropped);
         if (p == q) return 1'b1;
         for (int k = 0; k < edge_total; k++) begin
            if ((first_vtx[k] == p && second_vtx[k] == q) ||
                (first_vtx[k] == q && second_vtx[k] == p)) begin
               if (face_cnt[k] != COUNT_MAX) face_cnt[k]++;
               if (int'(face_cnt[k]) > peak_count) peak_count = int'(face_cnt[k]);
               return 1'b0;
            end
         end
         if (edge_total >= MAX_EDGES) begin
            dropped = 1'b1;
            return 1'b0;
         end
         first_vtx[edge_total]  = p;
         second_vtx[edge_total] = q;
         face_cnt[edge_total]   = COUNT_BITS'(1);
         edge_total++;
         return 1'b0;
      endfunction

      function void note_request(req_type item);
         rsp_type             rsp;
         bit                  dropped;
         logic [SKIP_BITS-1:0] skipped;
         rsp     = '0;
         dropped = 1'b0;
         skipped = '0;
         if (item.mode == MODE_ADD) begin
            skipped += tally_edge(item.vertex_a, item.vertex_b, dropped);
            skipped += tally_edge(item.vertex_b, item.vertex_c, dropped);
            skipped += tally_edge(item.vertex_c, item.vertex_a, dropped);
            rsp.skipped_degenerate = skipped;
            rsp.overflow           = dropped;
            triangles++;
            if (dropped) overflow_hits++;
         end else begin
            slot_reads++;
            if (int'(item.read_slot) < edge_total) begin
               rsp.slot_valid    = 1'b1;
               rsp.edge_start    = first_vtx[item.read_slot];
               rsp.edge_end      = second_vtx[item.read_slot];
               rsp.faces_on_edge = face_cnt[item.read_slot];
               rsp.streamer_risk = face_cnt[item.read_slot] > FACE_LIMIT;
            end
         end
         rsp.stored_edges = TOTAL_BITS'(edge_total);
         expected_rsp = {expected_rsp, rsp};
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
               $display("MISMATCH %s: expected 0x%0h, got 0x%0h", name, want, got);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("MISMATCH unexpected response 0x%0h", got);
            return;
         end
         want = expected_rsp.pop_front();
         compare_field("stored_edges", want.stored_edges, got.stored_edges);
         compare_field("skipped_degenerate", want.skipped_degenerate,
                       got.skipped_degenerate);
         compare_field("overflow", want.overflow, got.overflow);
         compare_field("slot_valid", want.slot_valid, got.slot_valid);
         compare_field("edge_start", want.edge_start, got.edge_start);
         compare_field("edge_end", want.edge_end, got.edge_end);
         compare_field("faces_on_edge", want.faces_on_edge, got.faces_on_edge);
         compare_field("streamer_risk", want.streamer_risk, got.streamer_risk);
      endfunction
   endclass

   logic clock;
   logic reset;
   int   gap_pct;
   int   stall_pct;

   nmec_req_if req_if ();
   nmec_rsp_if rsp_if ();

   edge_table_scoreboard sb = new();

   nonmanifold_edge_counter uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic int pick_gap(int pct);
      if (pct == 0 || $urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic req_type make_triangle(logic [VERTEX_BITS-1:0] a, b, c);
      req_type item;
      item           = '0;
      item.mode      = MODE_ADD;
      item.vertex_a  = a;
      item.vertex_b  = b;
      item.vertex_c  = c;
      item.read_slot = SLOT_BITS'($urandom_range(0, MAX_EDGES - 1));
      return item;
   endfunction

   function automatic req_type make_read(int slot);
      req_type item;
      item           = '0;
      item.mode      = MODE_READ;
      item.vertex_a  = VERTEX_BITS'($urandom_range(0, 65535));
      item.vertex_b  = VERTEX_BITS'($urandom_range(0, 65535));
      item.vertex_c  = VERTEX_BITS'($urandom_range(0, 65535));
      item.read_slot = SLOT_BITS'(slot);
      return item;
   endfunction

   function automatic logic [VERTEX_BITS-1:0] pool_vertex();
      if ($urandom_range(0, 99) < 85) return VERTEX_BITS'($urandom_range(0, 11));
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         2: return 16'h8000;
         default: return 16'h7FFF;
      endcase
   endfunction

   function automatic int any_slot();
      int hi;
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, MAX_EDGES - 1);
      hi = (sb.edge_total + 1 > MAX_EDGES - 1) ? MAX_EDGES - 1 : sb.edge_total + 1;
      return $urandom_range(0, hi);
   endfunction

   function automatic req_type random_item();
      logic [VERTEX_BITS-1:0] a, b;
      int                     sel;
      sel = $urandom_range(0, 99);
      a   = pool_vertex();
      b   = pool_vertex();
      if (sel < 40) return make_triangle(a, b, pool_vertex());
      if (sel < 50) begin
         case ($urandom_range(0, 3))
            0: return make_triangle(a, a, b);
            1: return make_triangle(a, b, b);
            2: return make_triangle(a, b, a);
            default: return make_triangle(a, a, a);
         endcase
      end
      if (sel < 80) return make_read(any_slot());
      if (sel < 95)
         return make_triangle(VERTEX_BITS'($urandom_range(0, 65535)),
                              VERTEX_BITS'($urandom_range(0, 65535)),
                              VERTEX_BITS'($urandom_range(0, 65535)));
      return make_triangle(a, b, a);
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      req_if.valid <= 1'b1;
      req_if.data  <= item;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.note_request(item);
      gap = pick_gap(gap_pct);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // response side: random backpressure, check each transfer
   initial begin
      int stall;
      stall = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            stall--;
         end else begin
            rsp_if.ready <= 1'b1;
            stall = pick_gap(stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         sb.check_response(rsp_if.data);
   end

   initial begin
      int k;
      int sat_slot;
      gap_pct      = 30;
      stall_pct    = 30;
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty read, extremes, orientation, degenerate edges
      send_item(make_read(0));
      send_item(make_triangle(16'h0000, 16'hFFFF, 16'h8000));
      send_item(make_triangle(16'hFFFF, 16'h0000, 16'h8000));
      send_item(make_read(0));
      send_item(make_read(1));
      send_item(make_read(2));
      send_item(make_triangle(16'd5, 16'd5, 16'd5));
      send_item(make_triangle(16'd5, 16'd5, 16'd6));
      send_item(make_triangle(16'd7, 16'd8, 16'd7));
      send_item(make_triangle(16'h0000, 16'hFFFF, 16'd1));
      send_item(make_read(0));
      send_item(make_read(3));
      send_item(make_read(MAX_EDGES - 1));
      send_item(make_read(sb.edge_total));
      send_item(make_read(sb.edge_total - 1));
      send_item(make_triangle(16'd1, 16'd2, 16'd3));
      send_item(make_triangle(16'd3, 16'd2, 16'd1));
      send_item(make_triangle(16'h5555, 16'hAAAA, 16'h5555));
      send_item(make_read(sb.edge_total - 1));
      wait_drained();

      // random mix on a small vertex pool; first stretch without idling
      gap_pct   = 0;
      stall_pct = 0;
      for (k = 0; k < 40; k++) begin
         if (k == 15) begin
            gap_pct   = 40;
            stall_pct = 40;
         end
         if (k == 30) stall_pct = 0;
         send_item(random_item());
      end
      wait_drained();

      // pump one edge twice per triangle until its count saturates
      gap_pct   = 20;
      stall_pct = 30;
      sat_slot  = sb.edge_total;
      for (k = 0; k < 130; k++) begin
         send_item(make_triangle(16'h0100, 16'h0200, 16'h0100));
         if (k % 32 == 31) send_item(make_read(sat_slot));
      end
      send_item(make_read(sat_slot));

      wait_drained();
      repeat (3200) @(posedge clock);

      $display("Run covered %0d triangles and %0d slot reads; table reached %0d of %0d edges.",
               sb.triangles, sb.slot_reads, sb.edge_total, MAX_EDGES);
      $display("%0d triangles overflowed, peak face count %0d, %0d mismatches.",
               sb.overflow_hits, sb.peak_count, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_rsp.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
